>>> design/fba_pkg.sv
// shared types and constants of the best-fit free-list allocator
package fba_pkg;

  // fixed field widths of the ports and the datapath, and the block header size
  localparam int OP_W       = 2;
  localparam int REQ_W      = 18;
  localparam int ADDR_W     = 17;
  localparam int FREE_W     = 18;
  localparam int STAT_W     = 3;
  localparam int NEED_W     = REQ_W + 1;
  localparam int HDR_BYTES  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_NO_FIT  = 3'd1,
    STAT_IGNORED = 3'd2,
    STAT_INSIDE  = 3'd3,
    STAT_FULL    = 3'd4
  } stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_SCAN, S_A_EXACT, S_A_REM, S_A_BEST, S_A_NOFIT, S_A_GRANT,
    S_F_CHECK, S_F_SIZE, S_F_IGN, S_F_SCAN, S_F_INSIDE, S_F_MERGE, S_F_FULL,
    S_F_PUSH_INIT, S_F_PUSH, S_F_HEAD, S_F_REL,
    S_D_OUTER, S_D_LOAD, S_D_SCAN, S_D_NEXT, S_D_MERGE, S_D_REM,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_SCAN, CMD_SET_STATUS,
    CMD_ALLOC_EXACT, CMD_ALLOC_BEST, CMD_ALLOC_GRANT,
    CMD_MOVE_DN, CMD_MOVE_UP,
    CMD_FREE_CHECK, CMD_FREE_SIZE, CMD_FREE_MERGE, CMD_PUSH_INIT,
    CMD_FREE_HEAD, CMD_FREE_REL,
    CMD_D_OUTER, CMD_D_LOAD, CMD_D_NEXT, CMD_D_MERGE
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    stat_t stat;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic scan_end;
    logic hit;
    logic hit_inside;
    logic have_best;
    logic mv_done;
    logic bad;
    logic size_zero;
    logic full;
    logic outer_end;
  } sts_t;

endpackage

>>> design/free_list_best_fit_allocator.sv
// top level of the best-fit free-list pool allocator
//
// A request is taken when start is high and busy is low; operation selects
// allocate, free or defragment, with request_bytes and block_address as
// operands. Each request gives exactly one result: done is high for one
// cycle with result_address, status and free_bytes; the receiver cannot
// stall, so the result must be taken in that cycle.
// Run time is set by the free-extent ram, read one entry per cycle, and by
// the number of live extents (at most MAX_EXTENTS): an allocate removes an
// exact extent when one matches, a free may push a new head extent, and a
// defragment restarts its scan from the head after each merge. A new
// request is taken the cycle after done.
// After reset every entry of the size store is cleared, one entry per cycle;
// busy stays high during that pass. The pool then holds one free extent
// covering all granules.
// GRANULE_BYTES must be a power of two.
module free_list_best_fit_allocator import fba_pkg::*; #(
  parameter int POOL_GRANULES = 4096,
  parameter int MAX_EXTENTS   = 64,
  parameter int GRANULE_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] block_address,
  output logic              done,
  output logic [ADDR_W-1:0] result_address,
  output logic [STAT_W-1:0] status,
  output logic [FREE_W-1:0] free_bytes
);

  ctl_t ctl;
  sts_t sts;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .done      (done)
  );

  fba_dpath #(
    .POOL_GRANULES (POOL_GRANULES),
    .MAX_EXTENTS   (MAX_EXTENTS),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .block_address  (block_address),
    .ctl            (ctl),
    .sts            (sts),
    .result_address (result_address),
    .status         (status),
    .free_bytes     (free_bytes)
  );

endmodule

>>> design/fba_ram.sv
// generic single-write, single-read ram with registered read
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fba_ctrl.sv
// controller state machine of the allocator
module fba_ctrl import fba_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] operation,
  input  sts_t            sts,
  output ctl_t            ctl,
  output logic            busy,
  output logic            done
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl.cmd    = CMD_NONE;
    ctl.stat   = STAT_OK;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.cmd = CMD_LOAD;
          case (op_t'(operation))
            OP_ALLOC:  state_next = S_A_SCAN;
            OP_FREE:   state_next = S_F_CHECK;
            OP_DEFRAG: state_next = S_D_OUTER;
            default:   state_next = S_DONE;
          endcase
        end
      end
      // allocate
      S_A_SCAN: begin
        ctl.cmd = CMD_SCAN;
        if (sts.hit) state_next = S_A_EXACT;
        else if (sts.scan_end) state_next = sts.have_best ? S_A_BEST : S_A_NOFIT;
      end
      S_A_EXACT: begin
        ctl.cmd    = CMD_ALLOC_EXACT;
        state_next = S_A_REM;
      end
      S_A_REM: begin
        ctl.cmd = CMD_MOVE_DN;
        if (sts.mv_done) state_next = S_A_GRANT;
      end
      S_A_BEST: begin
        ctl.cmd    = CMD_ALLOC_BEST;
        state_next = S_A_GRANT;
      end
      S_A_NOFIT: begin
        ctl.cmd    = CMD_SET_STATUS;
        ctl.stat   = STAT_NO_FIT;
        state_next = S_DONE;
      end
      S_A_GRANT: begin
        ctl.cmd    = CMD_ALLOC_GRANT;
        state_next = S_DONE;
      end
      // free
      S_F_CHECK: begin
        ctl.cmd    = CMD_FREE_CHECK;
        state_next = sts.bad ? S_F_IGN : S_F_SIZE;
      end
      S_F_SIZE: begin
        ctl.cmd    = CMD_FREE_SIZE;
        state_next = sts.size_zero ? S_F_IGN : S_F_SCAN;
      end
      S_F_IGN: begin
        ctl.cmd    = CMD_SET_STATUS;
        ctl.stat   = STAT_IGNORED;
        state_next = S_DONE;
      end
      S_F_SCAN: begin
        ctl.cmd = CMD_SCAN;
        if (sts.hit) state_next = sts.hit_inside ? S_F_INSIDE : S_F_MERGE;
        else if (sts.scan_end) state_next = sts.full ? S_F_FULL : S_F_PUSH_INIT;
      end
      S_F_INSIDE: begin
        ctl.cmd    = CMD_SET_STATUS;
        ctl.stat   = STAT_INSIDE;
        state_next = S_DONE;
      end
      S_F_MERGE: begin
        ctl.cmd    = CMD_FREE_MERGE;
        state_next = S_F_REL;
      end
      S_F_FULL: begin
        ctl.cmd    = CMD_SET_STATUS;
        ctl.stat   = STAT_FULL;
        state_next = S_DONE;
      end
      S_F_PUSH_INIT: begin
        ctl.cmd    = CMD_PUSH_INIT;
        state_next = S_F_PUSH;
      end
      S_F_PUSH: begin
        ctl.cmd = CMD_MOVE_UP;
        if (sts.mv_done) state_next = S_F_HEAD;
      end
      S_F_HEAD: begin
        ctl.cmd    = CMD_FREE_HEAD;
        state_next = S_F_REL;
      end
      S_F_REL: begin
        ctl.cmd    = CMD_FREE_REL;
        state_next = S_DONE;
      end
      // defragment
      S_D_OUTER: begin
        ctl.cmd    = CMD_D_OUTER;
        state_next = sts.outer_end ? S_DONE : S_D_LOAD;
      end
      S_D_LOAD: begin
        ctl.cmd    = CMD_D_LOAD;
        state_next = S_D_SCAN;
      end
      S_D_SCAN: begin
        ctl.cmd = CMD_SCAN;
        if (sts.hit) state_next = S_D_MERGE;
        else if (sts.scan_end) state_next = S_D_NEXT;
      end
      S_D_NEXT: begin
        ctl.cmd    = CMD_D_NEXT;
        state_next = S_D_OUTER;
      end
      S_D_MERGE: begin
        ctl.cmd    = CMD_D_MERGE;
        state_next = S_D_REM;
      end
      S_D_REM: begin
        ctl.cmd = CMD_MOVE_DN;
        if (sts.mv_done) state_next = S_D_OUTER;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/fba_dpath.sv
// datapath: extent list, size store, scan and shift engines
module fba_dpath import fba_pkg::*; #(
  parameter int POOL_GRANULES = 4096,
  parameter int MAX_EXTENTS   = 64,
  parameter int GRANULE_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OP_W-1:0]   operation,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0] block_address,
  input  ctl_t              ctl,
  output sts_t              sts,
  output logic [ADDR_W-1:0] result_address,
  output logic [STAT_W-1:0] status,
  output logic [FREE_W-1:0] free_bytes
);

  localparam int GW  = $clog2(POOL_GRANULES);
  localparam int LW  = GW + 1;
  localparam int EW  = GW + 2;
  localparam int PW  = $clog2(MAX_EXTENTS);
  localparam int CW  = $clog2(MAX_EXTENTS + 1);
  localparam int GSH = $clog2(GRANULE_BYTES);
  localparam int FW  = $clog2(POOL_GRANULES * GRANULE_BYTES + 1);
  localparam int AW  = GW + GSH;
  localparam int XW  = GW + LW;

  // control registers
  logic [CW-1:0]     cnt;
  logic [FW-1:0]     free_cnt;
  logic [GW-1:0]     clr;
  logic              dv;
  logic              wv;
  // working registers
  op_t               op_r;
  logic [NEED_W-1:0] need;
  logic [ADDR_W-1:0] ba_r;
  logic [CW-1:0]     idx;
  logic [PW-1:0]     pos_d;
  logic [CW-1:0]     ii;
  logic [CW-1:0]     sh;
  logic [PW-1:0]     waddr_d;
  logic              have_best;
  logic [PW-1:0]     best_pos;
  logic [GW-1:0]     best_s;
  logic [LW-1:0]     best_l;
  logic [PW-1:0]     hit_pos;
  logic [GW-1:0]     hit_s;
  logic [LW-1:0]     hit_l;
  logic [GW-1:0]     cur_s;
  logic [LW-1:0]     cur_l;
  logic [GW-1:0]     hg_r;
  logic [LW-1:0]     size;
  logic [GW-1:0]     blk;
  logic [ADDR_W-1:0] addr_r;
  stat_t             stat_r;

  // ram ports
  logic              ext_we, st_we;
  logic [PW-1:0]     ext_waddr, ext_raddr;
  logic [XW-1:0]     ext_wdata, ext_rdata;
  logic [GW-1:0]     st_waddr, st_raddr;
  logic [LW-1:0]     st_wdata, st_rdata;

  // decode of the entry being read
  logic [GW-1:0]     rd_s;
  logic [LW-1:0]     rd_l;
  logic [EW-1:0]     rd_end, cur_end;
  logic              a_exact, a_larger, f_inside, f_merge, d_match, match;
  logic              scan_issue, dn_issue, up_issue;
  logic [ADDR_W-1:0] ba_off;
  logic [ADDR_W-1:0] hg_full;
  logic [NEED_W-1:0] need_calc;
  logic [FW-1:0]     need_bytes, size_bytes;
  logic [LW-1:0]     best_rem;
  logic [AW-1:0]     addr_calc;

  assign rd_s    = ext_rdata[XW-1:LW];
  assign rd_l    = ext_rdata[LW-1:0];
  assign rd_end  = EW'(rd_s) + EW'(rd_l);
  assign cur_end = EW'(cur_s) + EW'(cur_l);

  // match tests for each operation
  assign a_exact  = NEED_W'(rd_l) == need;
  assign a_larger = NEED_W'(rd_l) > need;
  assign f_inside = (hg_r >= rd_s) && (EW'(hg_r) < rd_end);
  assign f_merge  = rd_end == EW'(hg_r);
  assign d_match  = (pos_d != PW'(ii)) && (EW'(rd_s) == cur_end);

  always_comb begin
    case (op_r)
      OP_ALLOC:  match = a_exact;
      OP_FREE:   match = f_inside || f_merge;
      OP_DEFRAG: match = d_match;
      default:   match = 1'b0;
    endcase
  end

  // issue conditions of the scan and shift engines
  assign scan_issue = (ctl.cmd == CMD_SCAN) && (idx < cnt);
  assign dn_issue   = (ctl.cmd == CMD_MOVE_DN) && ((CW+1)'(sh) + 1'b1 < (CW+1)'(cnt));
  assign up_issue   = (ctl.cmd == CMD_MOVE_UP) && (sh != '0);

  // address arithmetic
  assign ba_off     = ba_r - ADDR_W'(HDR_BYTES);
  assign hg_full    = ba_off >> GSH;
  assign need_calc  = NEED_W'((NEED_W'(request_bytes)
                      + NEED_W'(HDR_BYTES + GRANULE_BYTES - 1)) >> GSH);
  assign need_bytes = FW'(need) << GSH;
  assign size_bytes = FW'(size) << GSH;
  assign best_rem   = best_l - LW'(need);
  assign addr_calc  = (AW'(blk) << GSH) + AW'(HDR_BYTES);

  // status to the controller
  always_comb begin
    sts.clr_last   = clr == GW'(POOL_GRANULES - 1);
    sts.scan_end   = !dv && (idx >= cnt);
    sts.hit        = dv && match;
    sts.hit_inside = f_inside;
    sts.have_best  = have_best;
    sts.mv_done    = !wv && !dn_issue && !up_issue;
    sts.bad        = (ba_r < ADDR_W'(HDR_BYTES))
                     || (ba_off[GSH-1:0] != '0)
                     || (32'(hg_full) >= POOL_GRANULES);
    sts.size_zero  = st_rdata == '0;
    sts.full       = cnt >= CW'(MAX_EXTENTS);
    sts.outer_end  = ii >= cnt;
  end

  // extent ram read address
  always_comb begin
    case (ctl.cmd)
      CMD_SCAN:    ext_raddr = PW'(idx);
      CMD_MOVE_DN: ext_raddr = PW'(sh + 1'b1);
      CMD_MOVE_UP: ext_raddr = PW'(sh - 1'b1);
      default:     ext_raddr = PW'(ii);
    endcase
  end

  // extent ram write: shift engine first, then single entry updates
  always_comb begin
    ext_we    = 1'b0;
    ext_waddr = waddr_d;
    ext_wdata = ext_rdata;
    if (wv) begin
      ext_we = 1'b1;
    end else begin
      case (ctl.cmd)
        CMD_CLEAR: begin
          ext_we    = 1'b1;
          ext_waddr = '0;
          ext_wdata = {GW'(0), LW'(POOL_GRANULES)};
        end
        CMD_ALLOC_BEST: begin
          ext_we    = 1'b1;
          ext_waddr = best_pos;
          ext_wdata = {best_s, best_rem};
        end
        CMD_FREE_MERGE: begin
          ext_we    = 1'b1;
          ext_waddr = hit_pos;
          ext_wdata = {hit_s, LW'(hit_l + size)};
        end
        CMD_FREE_HEAD: begin
          ext_we    = 1'b1;
          ext_waddr = '0;
          ext_wdata = {hg_r, size};
        end
        CMD_D_MERGE: begin
          ext_we    = 1'b1;
          ext_waddr = PW'(ii);
          ext_wdata = {cur_s, LW'(cur_l + hit_l)};
        end
        default: begin
          ext_we = 1'b0;
        end
      endcase
    end
  end

  // size store access
  assign st_raddr = hg_full[GW-1:0];
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr;
    st_wdata = '0;
    case (ctl.cmd)
      CMD_CLEAR: begin
        st_we = 1'b1;
      end
      CMD_ALLOC_GRANT: begin
        st_we    = 1'b1;
        st_waddr = blk;
        st_wdata = LW'(need);
      end
      CMD_FREE_REL: begin
        st_we    = 1'b1;
        st_waddr = hg_r;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= CW'(1);
      free_cnt <= FW'(POOL_GRANULES * GRANULE_BYTES);
      clr      <= '0;
      dv       <= 1'b0;
      wv       <= 1'b0;
    end else begin
      dv <= scan_issue;
      wv <= dn_issue || up_issue;
      if (ctl.cmd == CMD_CLEAR) clr <= clr + 1'b1;
      if (ctl.cmd == CMD_MOVE_DN && !wv && !dn_issue) cnt <= cnt - 1'b1;
      if (ctl.cmd == CMD_FREE_HEAD) cnt <= cnt + 1'b1;
      if (ctl.cmd == CMD_ALLOC_GRANT) free_cnt <= free_cnt - need_bytes;
      if (ctl.cmd == CMD_FREE_REL) free_cnt <= free_cnt + size_bytes;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      idx   <= idx + 1'b1;
      pos_d <= PW'(idx);
    end
    if (dn_issue) begin
      waddr_d <= PW'(sh);
      sh      <= sh + 1'b1;
    end
    if (up_issue) begin
      waddr_d <= PW'(sh);
      sh      <= sh - 1'b1;
    end
    // latch the entry that ends a scan
    if (ctl.cmd == CMD_SCAN && dv && match) begin
      hit_pos <= pos_d;
      hit_s   <= rd_s;
      hit_l   <= rd_l;
    end
    // best-fit candidate tracking
    if (ctl.cmd == CMD_SCAN && dv && op_r == OP_ALLOC && !a_exact && a_larger
        && (!have_best || rd_l < best_l)) begin
      have_best <= 1'b1;
      best_pos  <= pos_d;
      best_s    <= rd_s;
      best_l    <= rd_l;
    end
    case (ctl.cmd)
      CMD_LOAD: begin
        op_r      <= op_t'(operation);
        need      <= need_calc;
        ba_r      <= block_address;
        idx       <= '0;
        ii        <= '0;
        have_best <= 1'b0;
        addr_r    <= '0;
        stat_r    <= STAT_OK;
      end
      CMD_SET_STATUS: begin
        stat_r <= ctl.stat;
      end
      CMD_ALLOC_EXACT: begin
        blk <= hit_s;
        sh  <= CW'(hit_pos);
      end
      CMD_ALLOC_BEST: begin
        blk <= GW'(best_s + best_rem);
      end
      CMD_ALLOC_GRANT: begin
        addr_r <= ADDR_W'(addr_calc);
      end
      CMD_FREE_CHECK: begin
        hg_r <= hg_full[GW-1:0];
      end
      CMD_FREE_SIZE: begin
        size <= st_rdata;
      end
      CMD_PUSH_INIT: begin
        sh <= cnt;
      end
      CMD_D_LOAD: begin
        cur_s <= rd_s;
        cur_l <= rd_l;
        idx   <= '0;
      end
      CMD_D_NEXT: begin
        ii <= ii + 1'b1;
      end
      CMD_D_MERGE: begin
        cur_l <= LW'(cur_l + hit_l);
        sh    <= CW'(hit_pos);
        ii    <= '0;
      end
      default: begin
      end
    endcase
  end

  fba_ram #(.WIDTH(XW), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  fba_ram #(.WIDTH(LW), .DEPTH(POOL_GRANULES)) u_size_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign result_address = addr_r;
  assign status         = stat_r;
  assign free_bytes     = FREE_W'(free_cnt);

endmodule

>>> design/fba_checker.sv
// port-level checks of the allocator, bound to the top level
module fba_checker import fba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [OP_W-1:0]   operation,
  input logic [REQ_W-1:0]  request_bytes,
  input logic [ADDR_W-1:0] block_address,
  input logic              done,
  input logic [ADDR_W-1:0] result_address,
  input logic [STAT_W-1:0] status,
  input logic [FREE_W-1:0] free_bytes
);

  // a taken request keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after request");

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  // failed requests return no address
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_OK |-> result_address == '0)
    else $error("address on failed request");

  // a failed allocate leaves the free count alone
  a_nofit_free: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_NO_FIT |-> $stable(free_bytes))
    else $error("free count moved on no fit");

endmodule

bind free_list_best_fit_allocator fba_checker u_fba_checker (.*);
